// ===== sv/srgb_max_normalize_pixel_defines.svh =====
// Assertion macros shared by the srgb_max_normalize_pixel RTL.
// Stand-alone header; included by the files that carry concurrent assertions.
`ifndef SRGB_MAX_NORMALIZE_PIXEL_DEFINES_SVH
`define SRGB_MAX_NORMALIZE_PIXEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SRGBMN_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked later, after the delay given by dly.
`define SRGBMN_ASSERT_DELAYED(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

// ===== sv/srgbmn_pkg.sv =====
// Package for the sRGB max-normalize pixel block: widths, types, latencies and the
// decode and threshold tables, both built at elaboration. No dependencies.
`default_nettype none

package srgbmn_pkg;

   localparam int LINEAR_BITS       = 16;
   localparam int ENCODE_INDEX_BITS = 12;

   localparam int PIX_BITS    = 8;
   localparam int CODE_COUNT  = 1 << PIX_BITS;
   localparam int NUM_CH      = 3;
   localparam int CH_RED      = 0;
   localparam int CH_GREEN    = 1;
   localparam int CH_BLUE     = 2;

   localparam int WEIGHT_BITS = 10;
   localparam int WEIGHT_FRAC = 8;

   // Linear values run from 0 to 1.0 inclusive, so one bit above the fraction.
   localparam int LIN_W       = LINEAR_BITS + 1;
   localparam int PEAK_W      = LIN_W + WEIGHT_BITS;
   localparam int IDX_W       = ENCODE_INDEX_BITS + 1;
   localparam int IDX_CALC_W  = LIN_W + ENCODE_INDEX_BITS + 1;
   localparam int PROBE_SHIFT = 30 - ENCODE_INDEX_BITS;
   localparam int DIV_STEPS   = LIN_W;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_W   = CSR_ADDR_W - 2;

   localparam int FRONT_LAT   = 3;
   localparam int NORM_LAT    = DIV_STEPS + 2;
   localparam int ENC_LAT     = PIX_BITS;
   localparam int PIPE_LAT    = FRONT_LAT + NORM_LAT + ENC_LAT;

   typedef logic [PIX_BITS-1:0]    pix_type;
   typedef logic [LIN_W-1:0]       lin_type;
   typedef logic [PEAK_W-1:0]      peak_type;
   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;
   typedef logic [REG_IDX_W-1:0]   reg_idx_type;

   localparam reg_idx_type REG_GREEN_WEIGHT   = reg_idx_type'(0);
   localparam weight_type  GREEN_WEIGHT_RESET = weight_type'(307);
   localparam lin_type     LIN_ONE            = {1'b1, {LINEAR_BITS{1'b0}}};

   typedef struct packed {
      lin_type [NUM_CH-1:0] lin;
      peak_type             peak;
   } front_type;

   typedef lin_type decode_table_type [CODE_COUNT];
   typedef idx_type thresh_table_type [CODE_COUNT];

   localparam longint unsigned Q_ONE  = 64'd1 << 30;
   localparam longint unsigned Q_HALF = 64'd1 << 29;

   function automatic longint unsigned q_mul(input longint unsigned a,
                                             input longint unsigned b);
      return (a * b + Q_HALF) >> 30;
   endfunction

   function automatic longint unsigned q_pow5(input longint unsigned y);
      longint unsigned y2;
      longint unsigned y4;
      y2 = q_mul(y, y);
      y4 = q_mul(y2, y2);
      return q_mul(y4, y);
   endfunction

   // sRGB code value m/510 to linear light in Q1.30.
   function automatic longint unsigned curve_lin(input longint unsigned m);
      longint unsigned num;
      longint unsigned b;
      longint unsigned b2;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned result;
      if (m * 64'd100000 <= 64'd2062950) begin
         result = (m * 64'd100 * Q_ONE + 64'd329460) / 64'd658920;
      end else begin
         num = 64'd100 * m + 64'd2805;
         b   = (num * Q_ONE + 64'd26902) / 64'd53805;
         if (b > Q_ONE) begin
            b = Q_ONE;
         end
         b2 = q_mul(b, b);
         lo = 64'd0;
         hi = Q_ONE;
         for (int i = 0; i < 32; i++) begin
            if (lo < hi) begin
               mid = (lo + hi + 64'd1) >> 1;
               if (q_pow5(mid) <= b2) begin
                  lo = mid;
               end else begin
                  hi = mid - 64'd1;
               end
            end
         end
         result = q_mul(b2, lo);
      end
      return result;
   endfunction

   function automatic decode_table_type build_decode_table();
      decode_table_type tab;
      longint unsigned  v;
      for (int i = 0; i < CODE_COUNT; i++) begin
         v      = curve_lin(64'(2 * i));
         tab[i] = LIN_W'((v + (64'd1 << (29 - LINEAR_BITS))) >> (30 - LINEAR_BITS));
      end
      return tab;
   endfunction

   // Half-code thresholds, expressed as the smallest encode index that reaches them.
   function automatic thresh_table_type build_thresh_table();
      thresh_table_type tab;
      longint unsigned  t;
      tab[0] = '0;
      for (int k = 1; k < CODE_COUNT; k++) begin
         t      = curve_lin(64'(2 * k - 1));
         tab[k] = IDX_W'((t + (64'd1 << PROBE_SHIFT) - 64'd1) >> PROBE_SHIFT);
      end
      return tab;
   endfunction

   localparam decode_table_type DECODE_TABLE = build_decode_table();
   localparam thresh_table_type THRESH_TABLE = build_thresh_table();

endpackage

`default_nettype wire

// ===== sv/srgbmn_csr.sv =====
// Configuration register file (APB-style) holding the green weight.
// Depends on srgbmn_pkg.
`default_nettype none

module srgbmn_csr
   import srgbmn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output weight_type            green_weight
);

   weight_type  weight_ff;
   weight_type  weight_in;
   reg_idx_type reg_idx;
   logic        write_en;

   assign pready   = 1'b1;
   assign reg_idx  = paddr[CSR_ADDR_W-1:2];
   assign write_en = psel && penable && pwrite && pready;

   always_comb begin
      weight_in = weight_ff;
      if (write_en && (reg_idx == REG_GREEN_WEIGHT)) begin
         weight_in = pwdata[WEIGHT_BITS-1:0];
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GREEN_WEIGHT: prdata = CSR_DATA_W'(weight_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= GREEN_WEIGHT_RESET;
      end else begin
         weight_ff <= weight_in;
      end
   end

   assign green_weight = weight_ff;

endmodule

`default_nettype wire

// ===== sv/srgbmn_front.sv =====
// Front end: per-channel decode to linear light, green weighting and the
// merge stage that forms the weighted maximum. Depends on srgbmn_pkg.
`default_nettype none

module srgbmn_front
   import srgbmn_pkg::*;
(
   input  logic                 clock,
   input  pix_type [NUM_CH-1:0] pix_in,
   input  weight_type           green_weight,
   output front_type            front_out
);

   lin_type   lin_s1_ff [NUM_CH];
   lin_type   lin_s1_in [NUM_CH];
   lin_type   lin_s2_ff [NUM_CH];
   peak_type  scaled_ff [NUM_CH];
   peak_type  scaled_in [NUM_CH];
   front_type front_ff;
   front_type front_in;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         lin_s1_in[c] = DECODE_TABLE[pix_in[c]];
      end
   end

   // Red and blue carry an implicit weight of 1.0 in the Q2.8 scale.
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         if (c == CH_GREEN) begin
            scaled_in[c] = PEAK_W'(lin_s1_ff[c]) * PEAK_W'(green_weight);
         end else begin
            scaled_in[c] = PEAK_W'(lin_s1_ff[c]) << WEIGHT_FRAC;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         front_in.lin[c] = lin_s2_ff[c];
      end
      front_in.peak = scaled_ff[CH_RED];
      if (scaled_ff[CH_GREEN] > front_in.peak) begin
         front_in.peak = scaled_ff[CH_GREEN];
      end
      if (scaled_ff[CH_BLUE] > front_in.peak) begin
         front_in.peak = scaled_ff[CH_BLUE];
      end
   end

   always_ff @(posedge clock) begin
      lin_s1_ff <= lin_s1_in;
      lin_s2_ff <= lin_s1_ff;
      scaled_ff <= scaled_in;
      front_ff  <= front_in;
   end

   assign front_out = front_ff;

endmodule

`default_nettype wire

// ===== sv/srgbmn_norm_lane.sv =====
// One channel lane: pipelined restoring divide of the linear value by the peak,
// saturation to 1.0 and rounding to the encode index. Depends on srgbmn_pkg.
`default_nettype none

module srgbmn_norm_lane
   import srgbmn_pkg::*;
(
   input  logic     clock,
   input  lin_type  lin_i,
   input  peak_type peak_i,
   output idx_type  idx_o
);

   peak_type rem_ff  [DIV_STEPS+1];
   peak_type peak_ff [DIV_STEPS+1];
   lin_type  quo_ff  [DIV_STEPS+1];
   logic     ovf_ff  [DIV_STEPS+1];
   logic     zero_ff [DIV_STEPS+1];
   idx_type  idx_ff;

   logic [PEAK_W:0]       top_val;
   peak_type              rem_in;
   logic                  ovf_in;
   logic                  zero_in;
   lin_type               ratio;
   logic [IDX_CALC_W-1:0] rounded;
   idx_type               idx_in;

   // The dividend is lin << (LINEAR_BITS + 8) plus half the peak. Its bits above
   // the quotient range start the remainder; if they already reach the peak, the
   // quotient exceeds the saturation point.
   always_comb begin
      top_val = ((PEAK_W + 1)'(lin_i) << (WEIGHT_FRAC - 1))
              + (PEAK_W + 1)'(peak_i >> (LINEAR_BITS + 2));
      rem_in  = top_val[PEAK_W-1:0];
      ovf_in  = top_val >= {1'b0, peak_i};
      zero_in = (peak_i == '0) && (lin_i == '0);
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= rem_in;
      peak_ff[0] <= peak_i;
      quo_ff[0]  <= '0;
      ovf_ff[0]  <= ovf_in;
      zero_ff[0] <= zero_in;
   end

   // One quotient bit per stage. The low dividend bits are the peak shifted
   // right by one, so each stage takes its next bit straight from the peak.
   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
      localparam int BitPos = DIV_STEPS + 1 - j;

      logic [PEAK_W:0] trial;
      logic [PEAK_W:0] diff;
      logic            take;
      peak_type        stage_rem_in;
      lin_type         stage_quo_in;

      always_comb begin
         trial        = {rem_ff[j-1], peak_ff[j-1][BitPos]};
         diff         = trial - {1'b0, peak_ff[j-1]};
         take         = trial >= {1'b0, peak_ff[j-1]};
         stage_rem_in = take ? diff[PEAK_W-1:0] : trial[PEAK_W-1:0];
         stage_quo_in = {quo_ff[j-1][LIN_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= stage_rem_in;
         quo_ff[j]  <= stage_quo_in;
         peak_ff[j] <= peak_ff[j-1];
         ovf_ff[j]  <= ovf_ff[j-1];
         zero_ff[j] <= zero_ff[j-1];
      end
   end

   always_comb begin
      if (zero_ff[DIV_STEPS]) begin
         ratio = '0;
      end else if (ovf_ff[DIV_STEPS] || (quo_ff[DIV_STEPS] > LIN_ONE)) begin
         ratio = LIN_ONE;
      end else begin
         ratio = quo_ff[DIV_STEPS];
      end
      rounded = (IDX_CALC_W'(ratio) << ENCODE_INDEX_BITS)
              + (IDX_CALC_W'(1) << (LINEAR_BITS - 1));
      idx_in  = rounded[LINEAR_BITS +: IDX_W];
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign idx_o = idx_ff;

endmodule

`default_nettype wire

// ===== sv/srgbmn_encode_lane.sv =====
// One channel lane: re-encodes an index to an 8-bit sRGB code by a pipelined
// binary search over the half-code threshold table. Depends on srgbmn_pkg.
`default_nettype none

module srgbmn_encode_lane
   import srgbmn_pkg::*;
(
   input  logic    clock,
   input  idx_type idx_i,
   output pix_type code_o
);

   idx_type idx_ff  [PIX_BITS-1];
   pix_type code_ff [PIX_BITS];

   // The thresholds rise with the code, so the number of thresholds at or below
   // the index is the largest code whose threshold is reached. Each stage decides
   // one code bit, most significant first.
   for (genvar s = 0; s < PIX_BITS; s++) begin : g_step
      localparam int BitPos = PIX_BITS - 1 - s;

      idx_type idx_prev;
      pix_type code_prev;
      pix_type cand;
      pix_type code_in;

      if (s == 0) begin : g_first
         assign idx_prev  = idx_i;
         assign code_prev = '0;
      end else begin : g_next
         assign idx_prev  = idx_ff[s-1];
         assign code_prev = code_ff[s-1];
      end

      always_comb begin
         cand    = code_prev | (pix_type'(1) << BitPos);
         code_in = (THRESH_TABLE[cand] <= idx_prev) ? cand : code_prev;
      end

      always_ff @(posedge clock) begin
         code_ff[s] <= code_in;
      end

      if (s < PIX_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            idx_ff[s] <= idx_prev;
         end
      end
   end

   assign code_o = code_ff[PIX_BITS-1];

endmodule

`default_nettype wire

// ===== sv/srgb_max_normalize_pixel.sv =====
// sRGB max-normalize pixel block, PIPE_LAT register stages deep from a request to its
// result (3 front-end stages, 19 in the divider lanes, 8 in the encoders).
// Throughput: one pixel per cycle, set by the fully pipelined divide of one quotient
// bit per stage and the one-bit-per-stage threshold search; busy is low outside reset.
// The receiver cannot stall, so results are never held. Reset is synchronous and
// active high: it clears the result valid line and sets green_weight to 307 (Q2.8).
`default_nettype none

`include "srgb_max_normalize_pixel_defines.svh"

module srgb_max_normalize_pixel
   import srgbmn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // Request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [PIX_BITS-1:0]   req_red_in,
   input  logic [PIX_BITS-1:0]   req_green_in,
   input  logic [PIX_BITS-1:0]   req_blue_in,

   // Result channel
   output logic                  rsp_strobe,
   output logic [PIX_BITS-1:0]   rsp_red_out,
   output logic [PIX_BITS-1:0]   rsp_green_out,
   output logic [PIX_BITS-1:0]   rsp_blue_out,

   // Configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // The datapath has no stall path and no state between pixels, so the only
   // time a request is refused is while reset is held.
   logic                 accept;
   logic [PIPE_LAT-1:0]  valid_ff;
   logic [PIPE_LAT-1:0]  valid_in;
   weight_type           green_weight;
   pix_type [NUM_CH-1:0] req_pix;
   front_type            front;
   idx_type              lane_idx  [NUM_CH];
   pix_type              lane_code [NUM_CH];

   assign busy   = reset;
   assign accept = start && !busy;

   srgbmn_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .green_weight (green_weight)
   );

   assign req_pix[CH_RED]   = req_red_in;
   assign req_pix[CH_GREEN] = req_green_in;
   assign req_pix[CH_BLUE]  = req_blue_in;

   // Decode all three channels, weight green and merge the lanes into the peak
   // that every channel is divided by. The user must change configuration only while
   // the pipeline is empty; the block does not enforce it, nor stage the weight.
   srgbmn_front u_front (
      .clock        (clock),
      .pix_in       (req_pix),
      .green_weight (green_weight),
      .front_out    (front)
   );

   // Three identical lanes, one per channel, each normalizing against the
   // shared peak and re-encoding to an 8-bit code.
   for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
      srgbmn_norm_lane u_norm (
         .clock  (clock),
         .lin_i  (front.lin[c]),
         .peak_i (front.peak),
         .idx_o  (lane_idx[c])
      );

      srgbmn_encode_lane u_encode (
         .clock  (clock),
         .idx_i  (lane_idx[c]),
         .code_o (lane_code[c])
      );
   end

   // The payload pipeline runs freely; this line marks which stages hold a
   // real request.
   assign valid_in = {valid_ff[PIPE_LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_strobe    = valid_ff[PIPE_LAT-1];
   assign rsp_red_out   = lane_code[CH_RED];
   assign rsp_green_out = lane_code[CH_GREEN];
   assign rsp_blue_out  = lane_code[CH_BLUE];

   // Every accepted request comes out exactly once, at the pipeline depth.
   `SRGBMN_ASSERT_DELAYED(a_result_at_latency, clock, reset, start && !busy, PIPE_LAT, rsp_strobe, "accepted request gave no result at the pipeline latency")
   `SRGBMN_ASSERT_IMPLY(a_result_has_request, clock, reset, rsp_strobe, $past(start && !busy, PIPE_LAT), "result strobe without a matching request")
   // An all-black pixel has a zero peak and must come out black.
   `SRGBMN_ASSERT_DELAYED(a_black_stays_black, clock, reset, start && !busy && (req_red_in == '0) && (req_green_in == '0) && (req_blue_in == '0), PIPE_LAT, (rsp_red_out == '0) && (rsp_green_out == '0) && (rsp_blue_out == '0), "black pixel did not give black")

endmodule

`default_nettype wire
